// ----- rtl/core/ispf_pkg.sv -----
// Shared types, codes and constants of the IP spoof prefix filter.
package ispf_pkg;

    localparam logic [31:0] LOOPBACK_ADDR   = 32'h7F00_0001;
    localparam logic [7:0]  RST_DEFAULT_TTL = 8'd64;
    localparam logic [7:0]  RST_TTL_LIMIT   = 8'd10;
    localparam logic [7:0]  RST_PAT_LIMIT   = 8'd5;

    // pid / 1000 == (pid * ID_RECIP) >> ID_RECIP_SHIFT for every 16-bit pid
    localparam logic [16:0] ID_RECIP       = 17'd67109;
    localparam int          ID_RECIP_SHIFT = 26;
    localparam int          ID_QUOT_W      = 7;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    localparam logic [2:0] STATUS_ADDED  = 3'd0;
    localparam logic [2:0] STATUS_FULL   = 3'd1;
    localparam logic [2:0] STATUS_PASSED = 3'd2;
    localparam logic [2:0] STATUS_CLEAN  = 3'd3;
    localparam logic [2:0] STATUS_SPOOF  = 3'd4;

    localparam logic [1:0] CFG_DEFAULT_TTL = 2'd0;
    localparam logic [1:0] CFG_TTL_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_PAT_LIMIT   = 2'd2;

    typedef struct packed {
        logic        pad;
        logic [15:0] packet_id;
        logic        whitelist_flag;
        logic [7:0]  ttl_value;
        logic [5:0]  prefix_len;
        logic [31:0] address;
    } t_ispf_in_data;

    typedef struct packed {
        logic [4:0] pad;
        logic       id_pattern;
        logic       zero_id;
        logic       ttl_anomaly;
        logic [7:0] expected_ttl_used;
    } t_ispf_out_data;

    typedef struct packed {
        logic [31:0] network;
        logic [31:0] mask;
        logic [7:0]  ttl;
        logic        white;
    } t_ispf_entry;

    localparam int ENTRY_W = $bits(t_ispf_entry);

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic add_do;
        logic eval_do;
    } t_ispf_cmd;

    typedef struct packed {
        logic hit;
        logic scan_done;
        logic out_free;
    } t_ispf_sts;

    function automatic logic [31:0] mask_of(input logic [5:0] len);
        mask_of = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

// ----- rtl/core/ispf_ram.sv -----
// Generic simple dual-port RAM with registered read.
module ispf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ispf_ctrl.sv -----
// Sequencing state machine of the IP spoof prefix filter.
module ispf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_action,
    output logic              o_in_ready,
    input  ispf_pkg::t_ispf_sts i_sts,
    output ispf_pkg::t_ispf_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADD  = 4'b0010,
        S_SCAN = 4'b0100,
        S_EVAL = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = i_rst_n;
                o_cmd.capture = i_in_valid && i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    n_state = (i_in_action == ispf_pkg::ACT_CHECK) ? S_SCAN : S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add_do = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.hit || i_sts.scan_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval_do = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/ispf_datapath.sv -----
// Prefix table, scan pointer, header checks and result register.
module ispf_datapath #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ispf_pkg::t_ispf_cmd     i_cmd,
    output ispf_pkg::t_ispf_sts     o_sts,
    input  ispf_pkg::t_ispf_in_data i_in_data,
    input  logic                    i_cfg_valid,
    input  logic [1:0]              i_cfg_index,
    input  logic [7:0]              i_cfg_data,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output ispf_pkg::t_ispf_out_data o_out_data,
    output logic [2:0]              o_out_status
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // configuration
    logic [7:0] r_default_ttl;
    logic [7:0] r_ttl_limit;
    logic [7:0] r_pat_limit;

    // control
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic          r_rd_vld;
    logic          r_out_vld;

    // item payload
    logic [31:0] r_addr;
    logic [5:0]  r_plen;
    logic [7:0]  r_ttl;
    logic        r_white_in;
    logic [15:0] r_pid;
    logic [ispf_pkg::ID_QUOT_W-1:0] r_quot;
    logic [7:0]  r_exp;
    logic        r_listed;

    // result
    logic [2:0]                r_status;
    ispf_pkg::t_ispf_out_data  r_out;

    ispf_pkg::t_ispf_entry w_wentry;
    ispf_pkg::t_ispf_entry w_rentry;
    logic [ispf_pkg::ENTRY_W-1:0] w_rdata;
    logic        w_full;
    logic        w_issue;
    logic        w_we;
    logic        w_hit;
    logic        w_done;
    logic [32:0] w_prod;
    logic [16:0] w_round;
    logic [7:0]  w_diff;
    logic        w_anom;
    logic        w_zid;
    logic        w_pat;
    logic        w_pass;

    assign w_full  = (r_count == CW'(TABLE_DEPTH));
    assign w_issue = i_cmd.scan_step && (r_idx != r_count);
    assign w_we    = i_cmd.add_do && !w_full;

    assign w_wentry.network = r_addr;
    assign w_wentry.mask    = ispf_pkg::mask_of(r_plen);
    assign w_wentry.ttl     = r_ttl;
    assign w_wentry.white   = r_white_in;

    ispf_ram #(
        .WIDTH (ispf_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wentry),
        .i_re    (w_issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rentry = w_rdata;
    assign w_hit  = r_rd_vld &&
                    ((r_addr & w_rentry.mask) == (w_rentry.network & w_rentry.mask));
    assign w_done = !r_rd_vld && (r_idx == r_count);

    assign o_sts.hit       = w_hit;
    assign o_sts.scan_done = w_done;
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    assign w_prod  = r_pid * ispf_pkg::ID_RECIP;
    assign w_round = ({10'd0, r_quot} << 10) - ({10'd0, r_quot} << 4)
                   - ({10'd0, r_quot} << 3);
    assign w_diff  = (r_ttl >= r_exp) ? (r_ttl - r_exp) : (r_exp - r_ttl);
    assign w_anom  = (w_diff > r_ttl_limit);
    assign w_zid   = (r_pid == 16'd0);
    assign w_pat   = (w_round == {1'b0, r_pid}) && (w_diff > r_pat_limit);
    assign w_pass  = (r_addr == ispf_pkg::LOOPBACK_ADDR) || r_listed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_ttl <= ispf_pkg::RST_DEFAULT_TTL;
            r_ttl_limit   <= ispf_pkg::RST_TTL_LIMIT;
            r_pat_limit   <= ispf_pkg::RST_PAT_LIMIT;
            r_count       <= '0;
            r_idx         <= '0;
            r_rd_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ispf_pkg::CFG_DEFAULT_TTL: r_default_ttl <= i_cfg_data;
                    ispf_pkg::CFG_TTL_LIMIT:   r_ttl_limit   <= i_cfg_data;
                    ispf_pkg::CFG_PAT_LIMIT:   r_pat_limit   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.capture) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= w_issue;
                if (w_issue) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            if (w_we) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.add_do || i_cmd.eval_do) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= w_prod[ispf_pkg::ID_RECIP_SHIFT +: ispf_pkg::ID_QUOT_W];
        if (i_cmd.capture) begin
            r_addr     <= i_in_data.address;
            r_plen     <= i_in_data.prefix_len;
            r_ttl      <= i_in_data.ttl_value;
            r_white_in <= i_in_data.whitelist_flag;
            r_pid      <= i_in_data.packet_id;
        end
        if (i_cmd.scan_step && w_hit) begin
            r_exp    <= w_rentry.ttl;
            r_listed <= w_rentry.white;
        end else if (i_cmd.scan_step && w_done) begin
            r_exp    <= r_default_ttl;
            r_listed <= 1'b0;
        end
        if (i_cmd.add_do) begin
            r_status <= w_full ? ispf_pkg::STATUS_FULL : ispf_pkg::STATUS_ADDED;
            r_out    <= '0;
        end else if (i_cmd.eval_do) begin
            r_out.pad               <= '0;
            r_out.expected_ttl_used <= r_exp;
            if (w_pass) begin
                r_status          <= ispf_pkg::STATUS_PASSED;
                r_out.ttl_anomaly <= 1'b0;
                r_out.zero_id     <= 1'b0;
                r_out.id_pattern  <= 1'b0;
            end else begin
                r_status          <= (w_anom || w_zid || w_pat) ?
                                     ispf_pkg::STATUS_SPOOF : ispf_pkg::STATUS_CLEAN;
                r_out.ttl_anomaly <= w_anom;
                r_out.zero_id     <= w_zid;
                r_out.id_pattern  <= w_pat;
            end
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_out_data   = r_out;
    assign o_out_status = r_status;

endmodule

// ----- rtl/core/ip_spoof_prefix_filter_top.sv -----
// Top level of the IP spoof prefix filter: ports, controller and datapath.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: header or entry, tuser: action
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: ttl and flags, tuser: status
//  cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// Add item or check item: the result is registered once the output register is free. A
// check scans the table from its first entry until the first match or the end of the
// table; one entry a cycle is read, up to TABLE_DEPTH entries.
// Reset clears the entry count and loads default configuration; table needs no clearing.
// A result waits in the output register; the next item is accepted meanwhile, and
// its own result is held back until that register is free.
module ip_spoof_prefix_filter_top #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] address, [37:32] prefix_len, [45:38] ttl_value,
    // [46] whitelist_flag, [62:47] packet_id, [63] zero
    input  logic [63:0] s_axis_tdata,
    // [0] action
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] expected_ttl_used, [8] ttl_anomaly, [9] zero_id, [10] id_pattern,
    // [15:11] zero
    output logic [15:0] m_axis_tdata,
    // [2:0] status
    output logic [2:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    ispf_pkg::t_ispf_cmd      w_cmd;
    ispf_pkg::t_ispf_sts      w_sts;
    ispf_pkg::t_ispf_out_data w_out_data;

    assign o_cfg_ready = i_rst_n;

    ispf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ispf_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_data    (ispf_pkg::t_ispf_in_data'(s_axis_tdata)),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (w_out_data),
        .o_out_status (m_axis_tuser)
    );

    assign m_axis_tdata = w_out_data;

endmodule

// ----- test/ip_spoof_prefix_filter_checker.sv -----
// Checker for the IP spoof prefix filter: predicts each verdict and compares the result stream.
module ip_spoof_prefix_filter_checker
    import ispf_pkg::*;
#(
    parameter int TABLE_DEPTH = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results,
    output int          o_passed,
    output int          o_spoofed,
    output int          o_full
);

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] ttl_used;
        logic       ttl_anomaly;
        logic       zero_id;
        logic       id_pattern;
    } t_verdict;

    logic [31:0] tab_net   [TABLE_DEPTH];
    logic [31:0] tab_mask  [TABLE_DEPTH];
    logic [7:0]  tab_ttl   [TABLE_DEPTH];
    logic        tab_white [TABLE_DEPTH];
    int          n_entries;

    logic [7:0] cfg_default_ttl;
    logic [7:0] cfg_ttl_limit;
    logic [7:0] cfg_pat_limit;

    t_verdict       pending_verdicts[$];
    t_verdict       want;
    t_ispf_out_data got;
    int             fails;
    int             n_results;
    int             n_passed;
    int             n_spoofed;
    int             n_full;

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        if (len == 6'd0) begin
            return 32'h0;
        end
        if (len >= 6'd32) begin
            return 32'hFFFF_FFFF;
        end
        return 32'hFFFF_FFFF << (32 - int'(len));
    endfunction

    function automatic t_verdict filter_verdict(input logic act, input t_ispf_in_data hdr);
        t_verdict    v;
        logic        listed;
        logic [7:0]  ref_ttl;
        int unsigned diff;
        v = '0;
        if (act == ACT_ADD) begin
            if (n_entries >= TABLE_DEPTH) begin
                v.status = STATUS_FULL;
            end else begin
                tab_net[n_entries]   = hdr.address;
                tab_mask[n_entries]  = prefix_mask(hdr.prefix_len);
                tab_ttl[n_entries]   = hdr.ttl_value;
                tab_white[n_entries] = hdr.whitelist_flag;
                n_entries++;
                v.status = STATUS_ADDED;
            end
            return v;
        end
        listed  = 1'b0;
        ref_ttl = cfg_default_ttl;
        for (int i = 0; i < n_entries; i++) begin
            if ((hdr.address & tab_mask[i]) == (tab_net[i] & tab_mask[i])) begin
                listed  = tab_white[i];
                ref_ttl = tab_ttl[i];
                break;
            end
        end
        v.ttl_used = ref_ttl;
        if (hdr.address == LOOPBACK_ADDR || listed) begin
            v.status = STATUS_PASSED;
            return v;
        end
        diff = (hdr.ttl_value >= ref_ttl) ? hdr.ttl_value - ref_ttl : ref_ttl - hdr.ttl_value;
        v.ttl_anomaly = diff > cfg_ttl_limit;
        v.zero_id     = hdr.packet_id == 16'd0;
        v.id_pattern  = ((hdr.packet_id % 16'd1000) == 16'd0) && (diff > cfg_pat_limit);
        v.status = (v.ttl_anomaly || v.zero_id || v.id_pattern) ? STATUS_SPOOF : STATUS_CLEAN;
        return v;
    endfunction

    task automatic compare_field(input string fname, input int unsigned exp_v,
                                 input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", fname, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_entries       = 0;
            cfg_default_ttl = RST_DEFAULT_TTL;
            cfg_ttl_limit   = RST_TTL_LIMIT;
            cfg_pat_limit   = RST_PAT_LIMIT;
            pending_verdicts.delete();
            fails     = 0;
            n_results = 0;
            n_passed  = 0;
            n_spoofed = 0;
            n_full    = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pending_verdicts.size() == 0) begin
                    $error("unexpected result: status %0d, expected_ttl_used %0d",
                           m_axis_tuser, got.expected_ttl_used);
                    fails++;
                end else begin
                    want = pending_verdicts.pop_front();
                    compare_field("status", want.status, m_axis_tuser);
                    compare_field("expected_ttl_used", want.ttl_used, got.expected_ttl_used);
                    compare_field("ttl_anomaly", want.ttl_anomaly, got.ttl_anomaly);
                    compare_field("zero_id", want.zero_id, got.zero_id);
                    compare_field("id_pattern", want.id_pattern, got.id_pattern);
                    n_results++;
                    if (want.status == STATUS_PASSED) n_passed++;
                    if (want.status == STATUS_SPOOF) n_spoofed++;
                    if (want.status == STATUS_FULL) n_full++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pending_verdicts.push_back(filter_verdict(s_axis_tuser[0],
                                                          t_ispf_in_data'(s_axis_tdata)));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEFAULT_TTL: cfg_default_ttl = i_cfg_data;
                    CFG_TTL_LIMIT:   cfg_ttl_limit   = i_cfg_data;
                    CFG_PAT_LIMIT:   cfg_pat_limit   = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_verdicts.size();
        o_results    <= n_results;
        o_passed     <= n_passed;
        o_spoofed    <= n_spoofed;
        o_full       <= n_full;
    end

endmodule

// ----- test/ip_spoof_prefix_filter_top_tb.sv -----
// Testbench top for the IP spoof prefix filter: stimulus, idling and the final verdict.
module ip_spoof_prefix_filter_top_tb;
    import ispf_pkg::*;

    localparam int DEPTH       = 512;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int PHASE_ITEMS = 229;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    int fail_count;
    int pending;
    int n_results;
    int n_passed;
    int n_spoofed;
    int n_full;

    int          cycle_count;
    logic        rush;
    int          n_adds;
    int          n_checks;
    int          n_writes;
    logic [7:0]  cur_default_ttl;
    logic [31:0] shadow_net [DEPTH];
    logic [5:0]  shadow_len [DEPTH];
    logic [7:0]  shadow_ttl [DEPTH];
    int          shadow_n;

    ip_spoof_prefix_filter_top #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    ip_spoof_prefix_filter_checker #(
        .TABLE_DEPTH(DEPTH)
    ) filter_check (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_results(n_results),
        .o_passed(n_passed),
        .o_spoofed(n_spoofed),
        .o_full(n_full)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    initial begin : result_sink
        int stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        forever begin
            stall = rush ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_item(input logic act, input logic [31:0] addr, input logic [5:0] plen,
                             input logic [7:0] ttl, input logic white, input logic [15:0] pid);
        int gap;
        gap = rush ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {1'b0, pid, white, ttl, plen, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        if (act == ACT_ADD) begin
            n_adds++;
            if (shadow_n < DEPTH) begin
                shadow_net[shadow_n] = addr;
                shadow_len[shadow_n] = plen;
                shadow_ttl[shadow_n] = ttl;
                shadow_n++;
            end
        end else begin
            n_checks++;
        end
    endtask

    // hold the sender until every outstanding result has drained
    task automatic hold_off();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        hold_off();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_DEFAULT_TTL) cur_default_ttl = val;
        n_writes++;
    endtask

    task automatic set_thresholds(input logic [7:0] dflt, input logic [7:0] lim,
                                  input logic [7:0] pat);
        write_reg(CFG_DEFAULT_TTL, dflt);
        write_reg(CFG_TTL_LIMIT, lim);
        write_reg(CFG_PAT_LIMIT, pat);
    endtask

    task automatic send_add();
        logic [5:0] plen;
        int         r;
        r = $urandom_range(0, 99);
        if (shadow_n == DEPTH - 1) begin
            // last slot takes a catch-all prefix so unmatched sources scan the whole table
            send_item(ACT_ADD, $urandom, 6'd0, 8'($urandom_range(0, 255)), 1'b0,
                      16'($urandom_range(0, 65535)));
        end else begin
            plen = (r < 55) ? 6'($urandom_range(12, 31)) :
                   (r < 85) ? 6'd32 : 6'($urandom_range(33, 63));
            send_item(ACT_ADD, $urandom, plen, 8'($urandom_range(0, 255)),
                      $urandom_range(0, 99) < 25, 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic send_check();
        int          pick;
        int          k;
        int          base;
        int          t;
        int          r;
        logic [31:0] addr;
        logic [31:0] m;
        logic [15:0] pid;
        pick = $urandom_range(0, 99);
        base = int'(cur_default_ttl);
        if (pick < 50 && shadow_n > 0) begin
            k    = $urandom_range(0, shadow_n - 1);
            m    = (shadow_len[k] == 6'd0) ? 32'h0 :
                   (shadow_len[k] >= 6'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> shadow_len[k]);
            addr = (shadow_net[k] & m) | ($urandom & ~m);
            base = int'(shadow_ttl[k]);
        end else if (pick < 58) begin
            addr = LOOPBACK_ADDR;
        end else if (pick < 66) begin
            addr = {8'h7F, 24'($urandom)};
        end else begin
            addr = $urandom;
        end
        if ($urandom_range(0, 99) < 35) begin
            t = $urandom_range(0, 255);
        end else begin
            t = base + int'($urandom_range(0, 30)) - 15;
            t = (t < 0) ? 0 : (t > 255) ? 255 : t;
        end
        r   = $urandom_range(0, 99);
        pid = (r < 20) ? 16'd0 :
              (r < 45) ? 16'($urandom_range(0, 65) * 1000) : 16'($urandom_range(0, 65535));
        send_item(ACT_CHECK, addr, 6'($urandom_range(0, 63)), t[7:0],
                  1'($urandom_range(0, 1)), pid);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        rush            = 1'b0;
        n_adds          = 0;
        n_checks        = 0;
        n_writes        = 0;
        shadow_n        = 0;
        cur_default_ttl = RST_DEFAULT_TTL;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: loopback, default TTL, limit and round-ID boundaries
        send_item(ACT_CHECK, LOOPBACK_ADDR, 6'd0, 8'd0, 1'b0, 16'd0);
        send_item(ACT_CHECK, 32'h7F00_0002, 6'd63, 8'd64, 1'b1, 16'd1);
        send_item(ACT_CHECK, 32'hFFFF_FFFF, 6'd0, 8'd255, 1'b0, 16'hFFFF);
        send_item(ACT_CHECK, 32'h0000_0000, 6'd0, 8'd64, 1'b0, 16'd0);
        send_item(ACT_CHECK, 32'h0102_0304, 6'd0, 8'd70, 1'b0, 16'd1000);
        send_item(ACT_CHECK, 32'h0102_0305, 6'd0, 8'd74, 1'b0, 16'd2000);
        send_item(ACT_CHECK, 32'h0102_0306, 6'd0, 8'd75, 1'b0, 16'd3000);
        send_item(ACT_CHECK, 32'h0102_0307, 6'd0, 8'd53, 1'b0, 16'd0);
        send_item(ACT_CHECK, 32'h0102_0308, 6'd0, 8'd69, 1'b0, 16'd5000);
        // adds: plain, whitelisted host, shadowed subnet, oversized prefix, loopback net
        send_item(ACT_ADD, 32'h0A00_0000, 6'd8, 8'd100, 1'b0, 16'hFFFF);
        send_item(ACT_ADD, 32'hC0A8_0105, 6'd32, 8'd0, 1'b1, 16'd0);
        send_item(ACT_ADD, 32'hC0A8_0100, 6'd24, 8'd255, 1'b0, 16'd0);
        send_item(ACT_ADD, 32'hAC10_0000, 6'd63, 8'd30, 1'b0, 16'd0);
        send_item(ACT_ADD, 32'h7F00_0000, 6'd8, 8'd1, 1'b0, 16'd0);
        send_item(ACT_CHECK, 32'h0A12_3456, 6'd0, 8'd100, 1'b0, 16'd7);
        send_item(ACT_CHECK, 32'hC0A8_0105, 6'd0, 8'd200, 1'b0, 16'd0);
        send_item(ACT_CHECK, 32'hC0A8_0106, 6'd0, 8'd255, 1'b0, 16'h8000);
        send_item(ACT_CHECK, 32'hC0A8_0106, 6'd0, 8'd0, 1'b0, 16'd65000);
        send_item(ACT_CHECK, 32'hAC10_0000, 6'd0, 8'd30, 1'b0, 16'd12);
        send_item(ACT_CHECK, 32'hAC10_0001, 6'd0, 8'd30, 1'b0, 16'd12);
        send_item(ACT_CHECK, LOOPBACK_ADDR, 6'd0, 8'd200, 1'b0, 16'd0);
        send_item(ACT_CHECK, 32'h7F00_0002, 6'd0, 8'd0, 1'b0, 16'd4);
        send_item(ACT_CHECK, 32'h7F12_3456, 6'd0, 8'd12, 1'b0, 16'd9000);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: set_thresholds(8'd0, 8'd0, 8'd0);
                2: set_thresholds(8'd255, 8'd255, 8'd255);
                3: set_thresholds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 40)),
                                  8'($urandom_range(0, 40)));
                4: set_thresholds(8'd64, 8'd0, 8'd255);
                default: ;
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                rush = (i >= 60 && i < 100);
                if ($urandom_range(0, 99) < ((shadow_n < DEPTH) ? 70 : 8)) begin
                    send_add();
                end else begin
                    send_check();
                end
            end
            rush = 1'b0;
        end

        hold_off();
        repeat (64) @(posedge i_clk);
        $display("run: %0d adds and %0d header checks over five threshold settings, %0d writes",
                 n_adds, n_checks, n_writes);
        $display("run: %0d results checked, %0d passed, %0d spoofed, %0d refused as table full",
                 n_results, n_passed, n_spoofed, n_full);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ispf_pkg.sv
rtl/core/ispf_ram.sv
rtl/core/ispf_ctrl.sv
rtl/core/ispf_datapath.sv
rtl/core/ip_spoof_prefix_filter_top.sv
test/ip_spoof_prefix_filter_checker.sv
test/ip_spoof_prefix_filter_top_tb.sv
